// ----- sv/bsim_pkg.sv -----
// ----------------------------------------------------------------------------
// bsim_pkg
// Types, codes and constants shared by the bank switch IRQ mapper files.
// ----------------------------------------------------------------------------
`default_nettype none

package bsim_pkg;

  localparam int CHR_BANKS = 8;
  localparam int CHR_IDX_W = $clog2(CHR_BANKS);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_AND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRG_OR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_AND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_OR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTRA    = 3'd5;

  // mapper register select, address bits 3..0
  localparam logic [3:0] REG_CHR_FIRST = 4'h0;
  localparam logic [3:0] REG_CHR_LAST  = 4'h7;
  localparam logic [3:0] REG_PRG       = 4'h8;
  localparam logic [3:0] REG_MIRROR    = 4'h9;
  localparam logic [3:0] REG_IRQ_CTRL  = 4'hA;
  localparam logic [3:0] REG_CNT_LO    = 4'hB;
  localparam logic [3:0] REG_CNT_HI    = 4'hC;
  localparam logic [3:0] REG_WRAM      = 4'hD;

  localparam logic [1:0] VARIANT_ORIGINAL = 2'd0;
  localparam logic [1:0] VARIANT_LATCH_HI = 2'd1;

  localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;
  localparam int         WRAM_EN_BIT    = 5;

  // output tdata bit positions
  localparam int OUT_IRQ_LSB    = 0;
  localparam int OUT_BANK_LSB   = 1;
  localparam int OUT_REGION_LSB = 13;
  localparam int OUT_MIRROR_LSB = 15;
  localparam int OUT_USED_W     = 17;
  localparam int OUT_TDATA_W    = 24;
  localparam int IN_TDATA_W     = 24;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_PRG   = 2'd2,
    CMD_CHR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REGION_ROM  = 2'd0,
    REGION_RAM  = 2'd1,
    REGION_OPEN = 2'd2,
    REGION_NONE = 2'd3
  } region_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0]  variant;
    logic [7:0]  prg_and_mask;
    logic [9:0]  prg_or_value;
    logic [7:0]  chr_and_mask;
    logic [11:0] chr_or_value;
    logic        extra_rom_present;
  } cfg_t;

  typedef struct packed {
    logic        irq_asserted;
    logic [11:0] bank;
    region_t     region_kind;
    logic [1:0]  mirror_mode;
  } res_t;

endpackage

`default_nettype wire

// ----- sv/bsim_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bsim_cfg_regs
// Configuration register file with plain write port, no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bsim_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [bsim_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bsim_pkg::cfg_t                      cfg
);
  import bsim_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VARIANT: cfg_nxt.variant           = cfg_wdata[1:0];
        CFG_PRG_AND: cfg_nxt.prg_and_mask      = cfg_wdata[7:0];
        CFG_PRG_OR:  cfg_nxt.prg_or_value      = cfg_wdata[9:0];
        CFG_CHR_AND: cfg_nxt.chr_and_mask      = cfg_wdata[7:0];
        CFG_CHR_OR:  cfg_nxt.chr_or_value      = cfg_wdata[11:0];
        CFG_EXTRA:   cfg_nxt.extra_rom_present = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.variant           <= VARIANT_ORIGINAL;
      cfg_r.prg_and_mask      <= 8'hFF;
      cfg_r.prg_or_value      <= '0;
      cfg_r.chr_and_mask      <= 8'hFF;
      cfg_r.chr_or_value      <= '0;
      cfg_r.extra_rom_present <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- sv/bsim_core.sv -----
// ----------------------------------------------------------------------------
// bsim_core
// Mapper state, register decode, IRQ counter and bank translation.
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  bsim_pkg::item_t      item,
  input  bsim_pkg::cfg_t       cfg,
  output bsim_pkg::res_t       res
);
  import bsim_pkg::*;

  logic [7:0]  prg_bank_r, prg_bank_nxt;
  logic [7:0]  chr_bank_r   [CHR_BANKS];
  logic [7:0]  chr_bank_nxt [CHR_BANKS];
  logic [1:0]  mirror_r, mirror_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] latch_r, latch_nxt;
  logic        irq_en_r, irq_en_nxt;
  logic        ram_en_r, ram_en_nxt;
  logic        irq_r, irq_nxt;

  logic                 direct;
  logic                 decoded;
  logic [15:0]          cnt_dec;
  logic [15:0]          cnt_load;
  logic [CHR_IDX_W-1:0] chr_idx;
  logic [CHR_IDX_W-1:0] wr_idx;

  assign direct  = (cfg.variant == VARIANT_ORIGINAL);
  assign cnt_dec = cnt_r - 16'd1;
  assign chr_idx = item.addr[10 +: CHR_IDX_W];
  assign wr_idx  = item.addr[CHR_IDX_W-1:0];
  assign cnt_load = direct ? cnt_r : latch_r;

  always_comb begin
    if (direct) begin
      decoded = (item.addr[15:13] == 3'b011);
    end else if (cfg.variant == VARIANT_LATCH_HI) begin
      decoded = item.addr[15];
    end else begin
      decoded = item.addr[15] | (item.addr[14] & item.addr[13]);
    end
  end

  // next state
  always_comb begin
    prg_bank_nxt = prg_bank_r;
    chr_bank_nxt = chr_bank_r;
    mirror_nxt   = mirror_r;
    cnt_nxt      = cnt_r;
    latch_nxt    = latch_r;
    irq_en_nxt   = irq_en_r;
    ram_en_nxt   = ram_en_r;
    irq_nxt      = irq_r;
    if (item.cmd == CMD_WRITE && decoded) begin
      unique case (item.addr[3:0]) inside
        [REG_CHR_FIRST:REG_CHR_LAST]: chr_bank_nxt[wr_idx] = item.data;
        REG_PRG:    prg_bank_nxt = item.data;
        REG_MIRROR: mirror_nxt   = item.data[1:0];
        REG_IRQ_CTRL: begin
          irq_en_nxt = item.data[0];
          cnt_nxt    = cnt_load;
          irq_nxt    = item.data[0] && (cnt_load == 16'd0);
        end
        REG_CNT_LO: begin
          if (direct) cnt_nxt   = {cnt_r[15:8], item.data};
          else        latch_nxt = {latch_r[15:8], item.data};
        end
        REG_CNT_HI: begin
          if (direct) cnt_nxt   = {item.data, cnt_r[7:0]};
          else        latch_nxt = {item.data, latch_r[7:0]};
        end
        REG_WRAM: begin
          if (!direct) ram_en_nxt = item.data[WRAM_EN_BIT];
        end
        default: ;
      endcase
    end else if (item.cmd == CMD_TICK && irq_en_r) begin
      cnt_nxt = cnt_dec;
      if (cnt_dec == 16'd0) irq_nxt = 1'b1;
    end
  end

  // result
  always_comb begin
    res.irq_asserted = irq_nxt;
    res.mirror_mode  = mirror_nxt;
    res.bank         = '0;
    res.region_kind  = REGION_NONE;
    case (item.cmd)
      CMD_PRG: begin
        if (item.addr[15:14] == 2'b11) begin
          res.bank        = {2'b00, {2'b00, PRG_FIXED_BANK & cfg.prg_and_mask}
                             | cfg.prg_or_value};
          res.region_kind = REGION_ROM;
        end else if (item.addr[15]) begin
          res.bank        = {2'b00, {2'b00, prg_bank_r & cfg.prg_and_mask}
                             | cfg.prg_or_value};
          res.region_kind = REGION_ROM;
        end else if (item.addr[14:13] == 2'b11) begin
          res.region_kind = (ram_en_r || cfg.extra_rom_present) ? REGION_RAM
                                                                : REGION_OPEN;
        end
      end
      CMD_CHR: begin
        res.bank        = {4'b0000, chr_bank_r[chr_idx] & cfg.chr_and_mask}
                          | cfg.chr_or_value;
        res.region_kind = REGION_ROM;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r <= '0;
      for (int i = 0; i < CHR_BANKS; i++) begin
        chr_bank_r[i] <= 8'(i);
      end
      mirror_r <= '0;
      cnt_r    <= '0;
      latch_r  <= '0;
      irq_en_r <= 1'b0;
      ram_en_r <= 1'b0;
      irq_r    <= 1'b0;
    end else if (fire) begin
      prg_bank_r <= prg_bank_nxt;
      chr_bank_r <= chr_bank_nxt;
      mirror_r   <= mirror_nxt;
      cnt_r      <= cnt_nxt;
      latch_r    <= latch_nxt;
      irq_en_r   <= irq_en_nxt;
      ram_en_r   <= ram_en_nxt;
      irq_r      <= irq_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/bank_switch_irq_mapper.sv -----
// An item loads the input register at its transfer, then the result register,
//   from which it leaves at the earliest output transfer.
// Throughput: one item per cycle unless the result stalls; the mapper state updates in a single pass.
// A stalled result holds the input register, which backs up in_tready.
// Reset (rst_n low, synchronous) empties both stages and restores registers.
// ----------------------------------------------------------------------------
// bank_switch_irq_mapper
// Cartridge mapper: bank registers, CPU-cycle IRQ counter, bank translation.
// ----------------------------------------------------------------------------
`default_nettype none

module bank_switch_irq_mapper (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [23:0]                    in_tdata,  // addr[15:0], data[23:16]
  input  wire logic [1:0]                     in_tuser,  // cmd[1:0]
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [23:0]                         out_tdata, // irq_asserted[0],
                                                         // bank[12:1],
                                                         // region_kind[14:13],
                                                         // mirror_mode[16:15],
                                                         // zero[23:17]
  input  wire logic                           cfg_we,
  input  wire logic [bsim_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [bsim_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bsim_pkg::*;

  cfg_t  cfg;
  res_t  res;
  item_t s1_item_r;
  logic  s1_vld_r;
  logic  out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic  out_free;
  logic  fire;

  assign out_free  = !out_vld_r || out_tready;
  assign fire      = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;

  bsim_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsim_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_tready) s1_vld_r <= in_tvalid;
      if (out_free)  out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.cmd  <= cmd_t'(in_tuser);
      s1_item_r.addr <= in_tdata[15:0];
      s1_item_r.data <= in_tdata[23:16];
    end
    if (fire) begin
      out_data_r <= {{(OUT_TDATA_W-OUT_USED_W){1'b0}}, res.mirror_mode,
                     res.region_kind, res.bank, res.irq_asserted};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- sv/bsim_checker.sv -----
// ----------------------------------------------------------------------------
// bsim_checker
// Port-level checks for the mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bsim_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);
  import bsim_pkg::*;

  logic [11:0] bank_f;
  logic [1:0]  region_f;

  assign bank_f   = out_tdata[OUT_BANK_LSB +: 12];
  assign region_f = out_tdata[OUT_REGION_LSB +: 2];

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // input backs up only behind a stalled, full result stage
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while result stage can advance");

  // only ROM lookups carry a bank number
  a_bank_rom: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && bank_f != 12'd0 |-> region_f == REGION_ROM)
    else $error("nonzero bank outside a ROM lookup");

endmodule

bind bank_switch_irq_mapper bsim_checker u_bsim_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
